>>> design/bxds_pkg.sv
// Shared types, register codes and widths for the box average downsampler.
package bxds_pkg;

  localparam int CHAN_W     = 8;
  localparam int SUM_W      = 14;
  localparam int FACTOR_W   = 4;
  localparam int WIDTH_W    = 12;
  localparam int HEIGHT_W   = 13;
  localparam int ROW_W      = 12;
  localparam int ROW_LIMIT  = 4096;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int QUEUE_DEPTH = 4;

  localparam int DEF_MAX_OUT_WIDTH = 2048;
  localparam int DEF_MAX_FACTOR    = 8;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic [FACTOR_W-1:0] RST_SCALE  = 4'd1;
  localparam logic [WIDTH_W-1:0]  RST_WIDTH  = 12'd1600;
  localparam logic [HEIGHT_W-1:0] RST_HEIGHT = 13'd1300;

  // Effective (clamped) configuration.
  typedef struct packed {
    logic [FACTOR_W-1:0] n;
    logic [WIDTH_W-1:0]  w;
    logic [HEIGHT_W-1:0] h;
  } cfg_eff_t;

  // One classified input pixel on its way to the accumulator.
  typedef struct packed {
    logic [CHAN_W-1:0] alpha;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
    logic              first;
    logic              last;
    logic              row_end;
    logic              frame_end;
  } pix_item_t;

  // One averaged output pixel.
  typedef struct packed {
    logic [CHAN_W-1:0] alpha;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
    logic              row_end;
    logic              frame_end;
  } out_pix_t;

endpackage

>>> design/bxds_queue.sv
// Small register FIFO between the front classifier and the accumulator.
module bxds_queue
  import bxds_pkg::*;
#(
  parameter int W     = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [W-1:0]  slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [NW-1:0] count_r;

  assign full  = (count_r == NW'(DEPTH));
  assign valid = (count_r != '0);
  assign rdata = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + NW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - NW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |-> (count_r != NW'(DEPTH)))
    else $error("queue overflow");
`endif

endmodule

>>> design/bxds_front.sv
// Front end: accept pixels, track block position, classify each pixel.
module bxds_front
  import bxds_pkg::*;
#(
  parameter int MAX_OUT_WIDTH = DEF_MAX_OUT_WIDTH,
  parameter int MAX_FACTOR    = DEF_MAX_FACTOR,
  localparam int CW = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cfg_eff_t      cfg,
  input  logic          cfg_we,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [31:0]   in_tdata,
  input  logic          in_tuser,
  output logic          q_push,
  output logic [CW-1:0] q_col,
  output pix_item_t     q_item,
  input  logic          q_full
);

  localparam int ICW = (MAX_OUT_WIDTH * MAX_FACTOR > 1) ?
                       $clog2(MAX_OUT_WIDTH * MAX_FACTOR) : 1;
  localparam int SCW = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
  localparam int RK  = ICW + FACTOR_W;
  localparam int P2  = 2 ** RK;
  localparam int MW  = ICW + FACTOR_W;

  // ceil(2^RK / n): exact quotient for any column index below 2^ICW.
  localparam logic [RK:0] DIV_RECIP [16] = '{
    '0,
    (RK+1)'(P2),               (RK+1)'((P2 + 1) / 2),   (RK+1)'((P2 + 2) / 3),
    (RK+1)'((P2 + 3) / 4),     (RK+1)'((P2 + 4) / 5),   (RK+1)'((P2 + 5) / 6),
    (RK+1)'((P2 + 6) / 7),     (RK+1)'((P2 + 7) / 8),   (RK+1)'((P2 + 8) / 9),
    (RK+1)'((P2 + 9) / 10),    (RK+1)'((P2 + 10) / 11), (RK+1)'((P2 + 11) / 12),
    (RK+1)'((P2 + 12) / 13),   (RK+1)'((P2 + 13) / 14), (RK+1)'((P2 + 14) / 15)
  };

  typedef enum logic [1:0] {S_RUN, S_CLAMP, S_MUL, S_SPLIT} state_t;

  state_t           state_r;
  logic [ICW-1:0]   ic_r;
  logic [CW-1:0]    col_r;
  logic [SCW-1:0]   sc_r;
  logic [SCW-1:0]   sr_r;
  logic [ROW_W-1:0] orow_r;
  logic [RK+ICW:0]  rs_prod_r;

  logic [ICW-1:0]   ic_nxt;
  logic [CW-1:0]    col_nxt;
  logic [SCW-1:0]   sc_nxt;
  logic [SCW-1:0]   sr_nxt;
  logic [ROW_W-1:0] orow_nxt;

  logic [ICW-1:0]   ic_cur;
  logic [CW-1:0]    col_cur;
  logic [SCW-1:0]   sc_cur;
  logic [SCW-1:0]   sr_cur;
  logic [ROW_W-1:0] orow_cur;
  logic             sc_end, col_end, sr_end, orow_end;
  logic [15:0]      in_w;
  logic [CW-1:0]    rs_col;
  logic [MW-1:0]    rs_base;

  assign in_tready = (state_r == S_RUN) && !q_full;
  assign q_push    = in_tvalid && in_tready;
  assign in_w      = 16'(cfg.w) * 16'(cfg.n);
  assign rs_col    = rs_prod_r[RK +: CW];
  assign rs_base   = MW'(rs_col) * MW'(cfg.n);

  always_comb begin
    // Frame start restarts the position before the pixel is placed.
    ic_cur   = in_tuser ? '0 : ic_r;
    col_cur  = in_tuser ? '0 : col_r;
    sc_cur   = in_tuser ? '0 : sc_r;
    sr_cur   = in_tuser ? '0 : sr_r;
    orow_cur = in_tuser ? '0 : orow_r;

    sc_end   = (FACTOR_W'(sc_cur) == cfg.n - FACTOR_W'(1));
    sr_end   = (FACTOR_W'(sr_cur) == cfg.n - FACTOR_W'(1));
    col_end  = (32'(col_cur) == 32'(cfg.w) - 32'd1);
    orow_end = (HEIGHT_W'(orow_cur) == cfg.h - HEIGHT_W'(1));

    q_col           = col_cur;
    q_item.red      = in_tdata[7:0];
    q_item.green    = in_tdata[15:8];
    q_item.blue     = in_tdata[23:16];
    q_item.alpha    = in_tdata[31:24];
    q_item.first    = (sr_cur == '0) && (sc_cur == '0);
    q_item.last     = sr_end && sc_end;
    q_item.row_end  = col_end;
    q_item.frame_end = col_end && orow_end;

    ic_nxt   = ic_cur + ICW'(1);
    col_nxt  = col_cur;
    sc_nxt   = sc_cur + SCW'(1);
    sr_nxt   = sr_cur;
    orow_nxt = orow_cur;
    if (sc_end) begin
      sc_nxt  = '0;
      col_nxt = col_cur + CW'(1);
      if (col_end) begin
        col_nxt = '0;
        ic_nxt  = '0;
        sr_nxt  = sr_cur + SCW'(1);
        if (sr_end) begin
          sr_nxt   = '0;
          orow_nxt = orow_end ? '0 : orow_cur + ROW_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RUN;
      ic_r    <= '0;
      col_r   <= '0;
      sc_r    <= '0;
      sr_r    <= '0;
      orow_r  <= '0;
    end else begin
      case (state_r)
        S_RUN: begin
          if (q_push) begin
            ic_r   <= ic_nxt;
            col_r  <= col_nxt;
            sc_r   <= sc_nxt;
            sr_r   <= sr_nxt;
            orow_r <= orow_nxt;
          end
        end
        S_CLAMP: begin
          // Drop any position left out of range by the new limits.
          if (32'(ic_r) >= 32'(in_w)) begin
            ic_r <= '0;
          end
          if (FACTOR_W'(sr_r) >= cfg.n) begin
            sr_r <= '0;
          end
          if (HEIGHT_W'(orow_r) >= cfg.h) begin
            orow_r <= '0;
          end
          state_r <= S_MUL;
        end
        S_MUL: begin
          rs_prod_r <= (RK+ICW+1)'(ic_r) * (RK+ICW+1)'(DIV_RECIP[cfg.n]);
          state_r   <= S_SPLIT;
        end
        S_SPLIT: begin
          col_r   <= rs_col;
          sc_r    <= SCW'(MW'(ic_r) - rs_base);
          state_r <= S_RUN;
        end
        default: begin
          state_r <= S_RUN;
        end
      endcase
      if (cfg_we) begin
        state_r <= S_CLAMP;
      end
    end
  end

`ifndef SYNTHESIS
  a_cfg_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_tready)
    else $error("input taken right after a configuration write");
  a_position_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> ((32'(ic_r) < 32'(in_w)) &&
      (FACTOR_W'(sc_r) < cfg.n) && (FACTOR_W'(sr_r) < cfg.n) &&
      (HEIGHT_W'(orow_r) < cfg.h)))
    else $error("block position out of range while running");
`endif

endmodule

>>> design/bxds_back.sv
// Back end: line-store accumulate, divide by block area, output register.
module bxds_back
  import bxds_pkg::*;
#(
  parameter int MAX_OUT_WIDTH = DEF_MAX_OUT_WIDTH,
  localparam int CW = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1,
  localparam int QW = CW + $bits(pix_item_t)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [FACTOR_W-1:0] n,
  input  logic                q_valid,
  input  logic [QW-1:0]       q_rdata,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output out_pix_t            out_pix
);

  localparam int EW = 4 * SUM_W;
  localparam int RS = 22;
  localparam int RW = RS + 1;
  localparam int PW = SUM_W + RW;
  localparam int AW = PW - RS;
  localparam int P2 = 2 ** RS;

  // ceil(2^RS / (n*n)); exact for every 14-bit sum.
  localparam logic [RW-1:0] AREA_RECIP [16] = '{
    '0,
    RW'(P2),                 RW'((P2 + 3) / 4),       RW'((P2 + 8) / 9),
    RW'((P2 + 15) / 16),     RW'((P2 + 24) / 25),     RW'((P2 + 35) / 36),
    RW'((P2 + 48) / 49),     RW'((P2 + 63) / 64),     RW'((P2 + 80) / 81),
    RW'((P2 + 99) / 100),    RW'((P2 + 120) / 121),   RW'((P2 + 143) / 144),
    RW'((P2 + 168) / 169),   RW'((P2 + 195) / 196),   RW'((P2 + 224) / 225)
  };

  logic [EW-1:0] sum_mem [MAX_OUT_WIDTH];

  logic [CW-1:0]              q_col;
  pix_item_t                  q_item;

  logic                       s1_valid_r;
  logic [CW-1:0]              s1_col_r;
  pix_item_t                  s1_item_r;
  logic [EW-1:0]              rd_data_r;
  logic                       fwd_r;
  logic [EW-1:0]              fwd_data_r;

  logic                       a_valid_r;
  logic [3:0][SUM_W-1:0]      a_sum_r;
  logic                       a_row_end_r, a_frame_end_r;

  logic                       b_valid_r;
  logic [3:0][PW-1:0]         prod_r;
  logic                       b_row_end_r, b_frame_end_r;

  logic                       out_valid_r;
  out_pix_t                   out_pix_r;

  logic [3:0][CHAN_W-1:0]     px;
  logic [EW-1:0]              old_entry;
  logic [EW-1:0]              wr_data;
  logic                       wr_en;
  logic                       o_free, b_go, b_free, a_go, a_free, s2_adv, s1_free;
  logic [3:0][CHAN_W-1:0]     avg8;

  assign q_col  = q_rdata[QW-1 -: CW];
  assign q_item = pix_item_t'(q_rdata[$bits(pix_item_t)-1:0]);

  assign o_free  = !out_valid_r || out_ready;
  assign b_go    = b_valid_r && o_free;
  assign b_free  = !b_valid_r || b_go;
  assign a_go    = a_valid_r && b_free;
  assign a_free  = !a_valid_r || a_go;
  assign s2_adv  = s1_valid_r && (!s1_item_r.last || a_free);
  assign s1_free = !s1_valid_r || s2_adv;
  assign q_pop   = q_valid && s1_free;
  assign wr_en   = s2_adv;

  assign out_valid = out_valid_r;
  assign out_pix   = out_pix_r;

  always_comb begin
    px        = {s1_item_r.alpha, s1_item_r.blue, s1_item_r.green, s1_item_r.red};
    old_entry = fwd_r ? fwd_data_r : rd_data_r;
    for (int k = 0; k < 4; k++) begin
      // First pixel of a block overwrites; the rest add, wrapping at 14 bits.
      wr_data[k*SUM_W +: SUM_W] = s1_item_r.first ? SUM_W'(px[k]) :
                                  old_entry[k*SUM_W +: SUM_W] + SUM_W'(px[k]);
    end
  end

  always_comb begin
    logic [AW-1:0] avg;
    for (int k = 0; k < 4; k++) begin
      avg     = prod_r[k][PW-1:RS];
      avg8[k] = (avg > AW'(255)) ? 8'hFF : avg[CHAN_W-1:0];
    end
  end

  // Line store: one write from the accumulate stage, one registered read per pop.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      sum_mem[s1_col_r] <= wr_data;
    end
    if (q_pop) begin
      rd_data_r <= sum_mem[q_col];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_col_r   <= q_col;
      s1_item_r  <= q_item;
      // Read collides with the write going out this cycle: keep that value.
      fwd_r      <= wr_en && (s1_col_r == q_col);
      fwd_data_r <= wr_data;
    end
    if (s2_adv && s1_item_r.last) begin
      for (int k = 0; k < 4; k++) begin
        a_sum_r[k] <= wr_data[k*SUM_W +: SUM_W];
      end
      a_row_end_r   <= s1_item_r.row_end;
      a_frame_end_r <= s1_item_r.frame_end;
    end
    if (a_go) begin
      for (int k = 0; k < 4; k++) begin
        prod_r[k] <= PW'(a_sum_r[k]) * PW'(AREA_RECIP[n]);
      end
      b_row_end_r   <= a_row_end_r;
      b_frame_end_r <= a_frame_end_r;
    end
    if (b_go) begin
      out_pix_r.red       <= avg8[0];
      out_pix_r.green     <= avg8[1];
      out_pix_r.blue      <= avg8[2];
      out_pix_r.alpha     <= avg8[3];
      out_pix_r.row_end   <= b_row_end_r;
      out_pix_r.frame_end <= b_frame_end_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        s1_valid_r <= 1'b1;
      end else if (s2_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s2_adv && s1_item_r.last) begin
        a_valid_r <= 1'b1;
      end else if (a_go) begin
        a_valid_r <= 1'b0;
      end
      if (a_go) begin
        b_valid_r <= 1'b1;
      end else if (b_go) begin
        b_valid_r <= 1'b0;
      end
      if (b_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_sum_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && !b_free) |=> (a_valid_r && $stable(a_sum_r)))
    else $error("block sum lost while divider stalled");
  a_accum_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_adv) |=> (s1_valid_r && $stable(s1_col_r) && $stable(fwd_r)))
    else $error("accumulate stage changed while stalled");
`endif

endmodule

>>> design/box_average_downsampler.sv
// Top level of the box average downsampler: config registers and wiring.
//
// Usage:
//   in_*   : RGBA8 pixels of the supersampled frame in raster order, n times the
//            output size in each direction. in_tuser marks the first pixel of a
//            frame and restarts the block position.
//   out_*  : one averaged pixel per completed n by n block; out_tlast marks the
//            last pixel of an output row, out_tuser the last pixel of the frame.
//   cfg_*  : write-only registers (scale factor, output width, output height);
//            write them only while the block is idle.
// Throughput: one item per clock while out_tready stays high, limited by the
// single read and single write port of the column-sum line store and the
// forwarding of back-to-back updates to the same column. After each
// configuration write the front end holds in_tready low while it realigns its
// block position (clamp, reciprocal multiply, split into column and sub-column).
// Path: a result shows on out_tvalid once the item that completes its block has
// passed the queue, store read, accumulate, multiply and output registers.
// Reset: counters and handshake state clear; registers return to 1, 1600 and
// 1300; the line store is not cleared, as every block overwrites before use.
// Stall: the output register holds while out_tready is low; the back end and
// a four-item queue fill up and then in_tready falls.
module box_average_downsampler
  import bxds_pkg::*;
#(
  parameter int MAX_OUT_WIDTH = DEF_MAX_OUT_WIDTH,
  parameter int MAX_FACTOR    = DEF_MAX_FACTOR
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [31:0]           in_tdata,   // red_in, green_in, blue_in, alpha_in
  input  logic                  in_tuser,   // frame_start
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,  // red_out, green_out, blue_out, alpha_out
  output logic                  out_tlast,  // row_end
  output logic                  out_tuser,  // frame_end
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CW = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
  localparam int QW = CW + $bits(pix_item_t);

  logic [FACTOR_W-1:0] scale_r;
  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  cfg_eff_t            cfg_eff;

  logic                q_push, q_full, q_pop, q_valid;
  logic [CW-1:0]       q_col;
  pix_item_t           q_item;
  logic [QW-1:0]       q_rdata;
  out_pix_t            out_pix;

  // Hold the raw register values; an unknown index is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= RST_SCALE;
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCALE:  scale_r  <= cfg_wdata[FACTOR_W-1:0];
        REG_WIDTH:  width_r  <= cfg_wdata[WIDTH_W-1:0];
        REG_HEIGHT: height_r <= cfg_wdata[HEIGHT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Zero acts as one; oversized values saturate to the supported limits.
  always_comb begin
    if (scale_r == '0) begin
      cfg_eff.n = FACTOR_W'(1);
    end else if (32'(scale_r) > MAX_FACTOR) begin
      cfg_eff.n = FACTOR_W'(MAX_FACTOR);
    end else begin
      cfg_eff.n = scale_r;
    end
    if (width_r == '0) begin
      cfg_eff.w = WIDTH_W'(1);
    end else if (32'(width_r) > MAX_OUT_WIDTH) begin
      cfg_eff.w = WIDTH_W'(MAX_OUT_WIDTH);
    end else begin
      cfg_eff.w = width_r;
    end
    if (height_r == '0) begin
      cfg_eff.h = HEIGHT_W'(1);
    end else if (32'(height_r) > ROW_LIMIT) begin
      cfg_eff.h = HEIGHT_W'(ROW_LIMIT);
    end else begin
      cfg_eff.h = height_r;
    end
  end

  bxds_front #(
    .MAX_OUT_WIDTH(MAX_OUT_WIDTH),
    .MAX_FACTOR   (MAX_FACTOR)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_eff),
    .cfg_we   (cfg_we),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .q_push   (q_push),
    .q_col    (q_col),
    .q_item   (q_item),
    .q_full   (q_full)
  );

  bxds_queue #(
    .W    (QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata({q_col, q_item}),
    .full (q_full),
    .pop  (q_pop),
    .valid(q_valid),
    .rdata(q_rdata)
  );

  bxds_back #(
    .MAX_OUT_WIDTH(MAX_OUT_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .n        (cfg_eff.n),
    .q_valid  (q_valid),
    .q_rdata  (q_rdata),
    .q_pop    (q_pop),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_pix  (out_pix)
  );

  assign out_tdata = {out_pix.alpha, out_pix.blue, out_pix.green, out_pix.red};
  assign out_tlast = out_pix.row_end;
  assign out_tuser = out_pix.frame_end;

endmodule
